FILE: rtl/core/mbps_pkg.sv
// ----------------------------------------------------------------------------
// mbps_pkg
// Shared types and constants for the masked byte pattern scanner.
// ----------------------------------------------------------------------------
`default_nettype none

package mbps_pkg;

    localparam int BYTE_W            = 8;
    localparam int ADDR_W            = 64;
    localparam int COUNT_W           = 32;
    localparam int LEN_CFG_W         = 5;
    localparam int CARE_W            = 16;
    localparam int REG_PATTERN_BYTES = 16;
    localparam int CFG_DATA_W        = 64;
    localparam int CFG_INDEX_W       = 3;

    // Configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_LOW  = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_HIGH = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_CARE_MASK    = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_LEN  = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_BASE_ADDRESS = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_MAX_MATCHES  = 3'd5;

    typedef struct packed {
        logic [BYTE_W-1:0] data_byte;
        logic              last_byte;
    } in_t;

    typedef struct packed {
        logic              match_found;
        logic [ADDR_W-1:0] match_address;
        logic              scan_done;
    } out_t;

    // Pattern settings handed to the compare unit
    typedef struct packed {
        logic [REG_PATTERN_BYTES*BYTE_W-1:0] pattern;
        logic [CARE_W-1:0]                   care_mask;
    } match_cfg_t;

endpackage

`default_nettype wire

FILE: rtl/core/masked_byte_pattern_scan.sv
// ----------------------------------------------------------------------------
// masked_byte_pattern_scan
// Wildcard byte signature search over a streamed buffer.
// ----------------------------------------------------------------------------
// One byte beat is accepted per clock sustained. A beat is held in an input
// register, and the masked compare over the newest len window bytes, the
// offset subtract and the base address add run on it combinationally; the
// result is registered into the output register when the beat advances. Only
// matches and the final byte produce a result beat. byte_ready drops only
// while both the input and output registers are full and result_ready is low.
// Write configuration only while no beats are in flight.
`default_nettype none

module masked_byte_pattern_scan #(
    parameter int PATTERN_BYTES = 16,
    parameter int OFFSET_WIDTH  = 32
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                byte_valid,
    output logic                                byte_ready,
    input  mbps_pkg::in_t                       byte_data,
    output logic                                result_valid,
    input  logic                                result_ready,
    output mbps_pkg::out_t                      result_data,
    input  logic                                cfg_write,
    input  logic [mbps_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [mbps_pkg::CFG_DATA_W-1:0]     cfg_data
);

    import mbps_pkg::*;

    localparam int FILL_W = $clog2(PATTERN_BYTES + 1);

    // Configuration
    logic [CFG_DATA_W-1:0] pattern_low_reg;
    logic [CFG_DATA_W-1:0] pattern_high_reg;
    logic [CARE_W-1:0]     care_mask_reg;
    logic [LEN_CFG_W-1:0]  pattern_length_reg;
    logic [ADDR_W-1:0]     base_address_reg;
    logic [COUNT_W-1:0]    max_matches_reg;

    // Pipeline
    logic                  in_valid_reg;
    in_t                   in_data_reg;
    logic                  result_valid_reg;
    out_t                  result_data_reg;

    // Scan state
    logic [PATTERN_BYTES-1:0][7:0] window_reg;
    logic [PATTERN_BYTES-1:0][7:0] window_next;
    logic [FILL_W-1:0]             fill_reg;
    logic [FILL_W-1:0]             fill_next;
    logic [OFFSET_WIDTH-1:0]       bytes_seen_reg;
    logic [OFFSET_WIDTH-1:0]       bytes_seen_next;
    logic [COUNT_W-1:0]            matches_reported_reg;
    logic [COUNT_W-1:0]            matches_reported_next;

    logic                    advance;
    logic [FILL_W-1:0]       len;
    logic                    hit;
    logic                    room;
    logic                    found;
    logic [OFFSET_WIDTH-1:0] offset;
    logic [ADDR_W-1:0]       address;
    match_cfg_t              match_cfg;

    assign advance    = in_valid_reg && (!result_valid_reg || result_ready);
    assign byte_ready = !in_valid_reg || advance;

    assign result_valid = result_valid_reg;
    assign result_data  = result_data_reg;

    // ---------------- configuration ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pattern_low_reg    <= '0;
            pattern_high_reg   <= '0;
            care_mask_reg      <= '0;
            pattern_length_reg <= LEN_CFG_W'(1);
            base_address_reg   <= '0;
            max_matches_reg    <= '0;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_PATTERN_LOW:  pattern_low_reg    <= cfg_data;
                REG_PATTERN_HIGH: pattern_high_reg   <= cfg_data;
                REG_CARE_MASK:    care_mask_reg      <= cfg_data[CARE_W-1:0];
                REG_PATTERN_LEN:  pattern_length_reg <= cfg_data[LEN_CFG_W-1:0];
                REG_BASE_ADDRESS: base_address_reg   <= cfg_data;
                REG_MAX_MATCHES:  max_matches_reg    <= cfg_data[COUNT_W-1:0];
                default:          ;
            endcase
        end
    end

    // ---------------- compare and step logic ----------------
    always_comb
    begin
        window_next[0] = in_data_reg.data_byte;
        for (int k = 1; k < PATTERN_BYTES; k++)
        begin
            window_next[k] = window_reg[k-1];
        end
    end

    always_comb
    begin
        if (int'(pattern_length_reg) > PATTERN_BYTES)
        begin
            len = FILL_W'(PATTERN_BYTES);
        end
        else
        begin
            len = FILL_W'(pattern_length_reg);
        end
    end

    assign match_cfg.pattern   = {pattern_high_reg, pattern_low_reg};
    assign match_cfg.care_mask = care_mask_reg;

    mbps_match #(
        .PATTERN_BYTES (PATTERN_BYTES),
        .LEN_W         (FILL_W)
    ) u_match (
        .window (window_next),
        .len    (len),
        .cfg    (match_cfg),
        .hit    (hit)
    );

    always_comb
    begin
        if (int'(fill_reg) < PATTERN_BYTES)
        begin
            fill_next = fill_reg + FILL_W'(1);
        end
        else
        begin
            fill_next = fill_reg;
        end
    end

    assign bytes_seen_next = bytes_seen_reg + OFFSET_WIDTH'(1);
    assign room  = (max_matches_reg == '0) || (matches_reported_reg < max_matches_reg);
    assign found = (len != '0) && (fill_next >= len) && hit && room;

    assign matches_reported_next = (found && (matches_reported_reg != '1)) ?
                                   matches_reported_reg + COUNT_W'(1) :
                                   matches_reported_reg;

    // Start offset of a match ending on this byte, wrapped to the counter width
    assign offset  = bytes_seen_next - OFFSET_WIDTH'(len);
    assign address = base_address_reg + ADDR_W'(offset);

    // ---------------- state ----------------
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            window_reg <= window_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg             <= '0;
            bytes_seen_reg       <= '0;
            matches_reported_reg <= '0;
        end
        else if (advance)
        begin
            if (in_data_reg.last_byte)
            begin
                fill_reg             <= '0;
                bytes_seen_reg       <= '0;
                matches_reported_reg <= '0;
            end
            else
            begin
                fill_reg             <= fill_next;
                bytes_seen_reg       <= bytes_seen_next;
                matches_reported_reg <= matches_reported_next;
            end
        end
    end

    // ---------------- input register ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (byte_valid && byte_ready)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (byte_valid && byte_ready)
        begin
            in_data_reg <= byte_data;
        end
    end

    // ---------------- result register ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            result_valid_reg <= found || in_data_reg.last_byte;
        end
        else if (result_ready)
        begin
            result_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            result_data_reg.match_found   <= found;
            result_data_reg.match_address <= found ? address : '0;
            result_data_reg.scan_done     <= in_data_reg.last_byte;
        end
    end

    // ---------------- assertions ----------------
    a_no_empty_result: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid_reg |-> (result_data_reg.match_found || result_data_reg.scan_done))
        else $error("result beat carries neither match nor done");

    a_address_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid_reg && !result_data_reg.match_found) |->
        (result_data_reg.match_address == '0))
        else $error("address nonzero without match");

    a_clear_on_last: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && in_data_reg.last_byte) |=>
        (fill_reg == '0 && bytes_seen_reg == '0 && matches_reported_reg == '0))
        else $error("counters not cleared after last byte");

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        int'(fill_reg) <= PATTERN_BYTES)
        else $error("window fill beyond window depth");

    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !byte_ready |-> (in_valid_reg && result_valid_reg && !result_ready))
        else $error("input stalled without a full pipeline");

endmodule

`default_nettype wire

FILE: rtl/core/mbps_match.sv
// ----------------------------------------------------------------------------
// mbps_match
// Masked compare of the newest len window bytes against the pattern.
// ----------------------------------------------------------------------------
`default_nettype none

module mbps_match #(
    parameter int PATTERN_BYTES = 16,
    parameter int LEN_W         = 5
) (
    input  logic [PATTERN_BYTES-1:0][7:0] window,
    input  logic [LEN_W-1:0]              len,
    input  mbps_pkg::match_cfg_t          cfg,
    output logic                          hit
);

    import mbps_pkg::*;

    localparam int NCMP  = (PATTERN_BYTES < REG_PATTERN_BYTES) ?
                           PATTERN_BYTES : REG_PATTERN_BYTES;
    localparam int AGE_W = (PATTERN_BYTES > 1) ? $clog2(PATTERN_BYTES) : 1;

    // Pattern byte i lines up with the byte received len-1-i beats ago;
    // bytes beyond the care mask are wildcards.
    always_comb
    begin
        logic [AGE_W-1:0] age;
        age = '0;
        hit = 1'b1;
        for (int i = 0; i < NCMP; i++)
        begin
            if ((int'(len) > i) && cfg.care_mask[i])
            begin
                age = AGE_W'(int'(len) - 1 - i);
                if (window[age] != cfg.pattern[BYTE_W*i +: BYTE_W])
                begin
                    hit = 1'b0;
                end
            end
        end
    end

endmodule

`default_nettype wire

FILE: sim/masked_byte_pattern_scan_test.sv
// ----------------------------------------------------------------------------
// masked_byte_pattern_scan_test
// Self-checking bench for the masked byte pattern scanner.
// ----------------------------------------------------------------------------
// Byte beats go in through valid/ready with random gaps. Each accepted beat is
// run through a software copy of the window compare, and the expected result
// beats are queued. Result beats are checked field by field as they leave.
// A directed opening covers the reset settings, wrap of the address sum,
// short buffers, the match limit, zero and oversized pattern lengths. Random
// phases follow, each with fresh register values and buffers that mostly
// carry planted pattern copies. One phase holds the result side off for a
// long stretch so that the block backs up.
// ----------------------------------------------------------------------------

module masked_byte_pattern_scan_test;
    timeunit 1ns;
    timeprecision 1ps;

    import mbps_pkg::*;

    localparam int WINDOW       = 16;
    localparam int STALL_LIMIT  = 2000;
    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_CYCLES = 8;
    localparam int IDLE_PCT     = 34;
    localparam int TARGET_BYTES = 1350;
    localparam int REG_COUNT    = int'(REG_MAX_MATCHES) + 1;

    // Tracks the scanner state and holds the result beats still to come
    class scan_tracker;
        logic [63:0] pat_low;
        logic [63:0] pat_high;
        logic [63:0] base;
        logic [15:0] care;
        logic [4:0]  plen;
        logic [31:0] limit;
        logic [7:0]  window [WINDOW];
        logic [31:0] seen;
        logic [31:0] reported;
        int          fill;
        out_t        pending [$];
        int          errors;

        function new();
            pat_low  = '0;
            pat_high = '0;
            base     = '0;
            care     = '0;
            plen     = 5'd1;
            limit    = '0;
            seen     = '0;
            reported = '0;
            fill     = 0;
            errors   = 0;
            foreach (window[k])
                window[k] = '0;
        endfunction

        function void write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
            case (idx)
                REG_PATTERN_LOW:  pat_low  = value;
                REG_PATTERN_HIGH: pat_high = value;
                REG_CARE_MASK:    care     = value[15:0];
                REG_PATTERN_LEN:  plen     = value[4:0];
                REG_BASE_ADDRESS: base     = value;
                REG_MAX_MATCHES:  limit    = value[31:0];
                default: ;
            endcase
        endfunction

        // pattern byte 0 lines up with the oldest of the newest len window bytes
        function bit window_hits(int len);
            logic [127:0] pat;
            logic [7:0]   want;
            pat = {pat_high, pat_low};
            for (int i = 0; i < len; i++)
            begin
                if (care[i])
                begin
                    want = pat[8*i +: 8];
                    if (window[len-1-i] !== want)
                        return 1'b0;
                end
            end
            return 1'b1;
        endfunction

        function void take_byte(in_t beat);
            int          len;
            logic [31:0] offset;
            bit          found;
            out_t        res;
            for (int k = WINDOW - 1; k > 0; k--)
                window[k] = window[k-1];
            window[0] = beat.data_byte;
            if (fill < WINDOW)
                fill++;
            seen = seen + 32'd1;
            len = (plen > WINDOW) ? WINDOW : int'(plen);
            found = 1'b0;
            if (len != 0 && fill >= len && window_hits(len))
            begin
                if (limit == '0 || reported < limit)
                begin
                    found = 1'b1;
                    if (reported != '1)
                        reported++;
                end
            end
            offset = seen - 32'(len);
            // window bytes survive the end of a buffer, the counters do not
            if (beat.last_byte)
            begin
                seen     = '0;
                reported = '0;
                fill     = 0;
            end
            if (found || beat.last_byte)
            begin
                res.match_found   = found;
                res.match_address = found ? base + {32'd0, offset} : '0;
                res.scan_done     = beat.last_byte;
                pending = {pending, res};
            end
        endfunction

        function void check_result(out_t got);
            out_t want;
            if (pending.size() == 0)
            begin
                $display("%0t: unexpected result beat %h", $time, got);
                errors++;
                return;
            end
            want = pending.pop_front();
            if (got.match_found !== want.match_found)
            begin
                $display("%0t: match_found expected %0d actual %0d",
                         $time, want.match_found, got.match_found);
                errors++;
            end
            if (got.match_address !== want.match_address)
            begin
                $display("%0t: match_address expected %h actual %h",
                         $time, want.match_address, got.match_address);
                errors++;
            end
            if (got.scan_done !== want.scan_done)
            begin
                $display("%0t: scan_done expected %0d actual %0d",
                         $time, want.scan_done, got.scan_done);
                errors++;
            end
        endfunction
    endclass

    logic                   clk          = 1'b0;
    logic                   rst_n        = 1'b0;
    logic                   byte_valid   = 1'b0;
    logic                   byte_ready;
    in_t                    byte_data    = '0;
    logic                   result_valid;
    logic                   result_ready = 1'b0;
    out_t                   result_data;
    logic                   cfg_write    = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index    = '0;
    logic [CFG_DATA_W-1:0]  cfg_data     = '0;

    scan_tracker            tracker;
    logic [CFG_DATA_W-1:0]  cfg_val [REG_COUNT];
    bit                     idling_on    = 1'b1;
    bit                     hold_req     = 1'b0;
    int                     hold_left    = 0;
    int                     stall_count  = 0;
    int                     bytes_sent   = 0;

    masked_byte_pattern_scan DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .byte_valid   (byte_valid),
        .byte_ready   (byte_ready),
        .byte_data    (byte_data),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result_data  (result_data),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    initial
    begin
        forever #2 clk = ~clk;
    end

    // result side: check accepted beats, then pick next ready
    always @(posedge clk)
    begin
        if (result_valid && result_ready)
            tracker.check_result(result_data);
        if (hold_left > 0)
        begin
            hold_left--;
            result_ready <= 1'b0;
        end
        else if (hold_req)
        begin
            hold_req = 1'b0;
            hold_left = HOLD_CYCLES;
            result_ready <= 1'b0;
        end
        else
        begin
            result_ready <= !idling_on || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    always @(posedge clk)
    begin
        if ((byte_valid && byte_ready) || (result_valid && result_ready))
            stall_count <= 0;
        else if (stall_count >= STALL_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
        else
            stall_count <= stall_count + 1;
    end

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    function automatic int active_len();
        int n;
        n = int'(cfg_val[REG_PATTERN_LEN][4:0]);
        return (n > WINDOW) ? WINDOW : n;
    endfunction

    task automatic send_byte(logic [7:0] data, logic last);
        in_t beat;
        beat.data_byte = data;
        beat.last_byte = last;
        while (idling_on && $urandom_range(99) < IDLE_PCT)
        begin
            byte_valid <= 1'b0;
            @(posedge clk);
        end
        byte_valid <= 1'b1;
        byte_data  <= beat;
        do
            @(posedge clk);
        while (!byte_ready);
        tracker.take_byte(beat);
        bytes_sent++;
    endtask

    // stop offering, wait out the queued results and the pipeline tail
    task automatic drain();
        byte_valid <= 1'b0;
        while (tracker.pending.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic load_config();
        for (int r = int'(REG_PATTERN_LOW); r <= int'(REG_MAX_MATCHES); r++)
        begin
            cfg_write <= 1'b1;
            cfg_index <= CFG_INDEX_W'(r);
            cfg_data  <= cfg_val[r];
            @(posedge clk);
            tracker.write_reg(CFG_INDEX_W'(r), cfg_val[r]);
        end
        cfg_write <= 1'b0;
    endtask

    task automatic set_config(logic [63:0] pat_low, logic [63:0] pat_high,
                              logic [15:0] care, logic [4:0] plen,
                              logic [63:0] base, logic [31:0] limit);
        cfg_val[REG_PATTERN_LOW]  = pat_low;
        cfg_val[REG_PATTERN_HIGH] = pat_high;
        cfg_val[REG_CARE_MASK]    = {48'd0, care};
        cfg_val[REG_PATTERN_LEN]  = {59'd0, plen};
        cfg_val[REG_BASE_ADDRESS] = base;
        cfg_val[REG_MAX_MATCHES]  = {32'd0, limit};
        load_config();
    endtask

    // narrow registers get junk in their upper bits, which must be ignored
    task automatic random_config();
        cfg_val[REG_PATTERN_LOW]  = rand64();
        cfg_val[REG_PATTERN_HIGH] = rand64();
        if ($urandom_range(7) == 0)
            cfg_val[REG_PATTERN_LOW] = $urandom_range(1) ? '1 : '0;
        if ($urandom_range(7) == 0)
            cfg_val[REG_PATTERN_HIGH] = $urandom_range(1) ? '1 : '0;
        cfg_val[REG_CARE_MASK] = rand64();
        case ($urandom_range(4))
            0: cfg_val[REG_CARE_MASK][15:0] = '1;
            1: cfg_val[REG_CARE_MASK][15:0] = '0;
            default: ;
        endcase
        cfg_val[REG_PATTERN_LEN] = rand64();
        case ($urandom_range(9))
            0: cfg_val[REG_PATTERN_LEN][4:0] = 5'd0;
            1: cfg_val[REG_PATTERN_LEN][4:0] = 5'($urandom_range(17, 31));
            2: cfg_val[REG_PATTERN_LEN][4:0] = 5'd16;
            3: cfg_val[REG_PATTERN_LEN][4:0] = 5'd1;
            default: cfg_val[REG_PATTERN_LEN][4:0] = 5'($urandom_range(1, 16));
        endcase
        case ($urandom_range(4))
            0: cfg_val[REG_BASE_ADDRESS] = '0;
            1: cfg_val[REG_BASE_ADDRESS] = '1;
            2: cfg_val[REG_BASE_ADDRESS] = 64'hFFFF_FFFF_FFFF_FFFF - $urandom_range(40);
            default: cfg_val[REG_BASE_ADDRESS] = rand64();
        endcase
        cfg_val[REG_MAX_MATCHES] = rand64();
        case ($urandom_range(7))
            0, 1, 2: cfg_val[REG_MAX_MATCHES][31:0] = '0;
            3: cfg_val[REG_MAX_MATCHES][31:0] = 32'd1;
            4: cfg_val[REG_MAX_MATCHES][31:0] = 32'($urandom_range(2, 3));
            5: cfg_val[REG_MAX_MATCHES][31:0] = '1;
            default: ;
        endcase
        load_config();
    endtask

    // random bytes with copies of the pattern dropped in; a spoilt copy has
    // one byte inverted
    task automatic send_buffer(int n, int plants, bit spoil);
        logic [7:0]   stream [$];
        logic [127:0] pat;
        int           len;
        int           start;
        int           pos;
        len = active_len();
        pat = {cfg_val[REG_PATTERN_HIGH], cfg_val[REG_PATTERN_LOW]};
        for (int i = 0; i < n; i++)
        begin
            case ($urandom_range(7))
                0: stream = {stream, 8'hFF};
                1: stream = {stream, 8'h00};
                default: stream = {stream, 8'($urandom)};
            endcase
        end
        if (len != 0 && n >= len)
        begin
            repeat (plants)
            begin
                start = $urandom_range(n - len);
                for (int i = 0; i < len; i++)
                    if (cfg_val[REG_CARE_MASK][i])
                        stream[start+i] = pat[8*i +: 8];
                if (spoil)
                begin
                    pos = start + $urandom_range(len - 1);
                    stream[pos] = ~stream[pos];
                end
            end
        end
        for (int i = 0; i < n; i++)
            send_byte(stream[i], i == n - 1);
    endtask

    task automatic random_phase(int quota);
        int phase_bytes;
        int n;
        random_config();
        phase_bytes = 0;
        while (phase_bytes < quota)
        begin
            case ($urandom_range(9))
                0, 1:
                begin
                    n = $urandom_range(1, 24);
                    send_buffer(n, 0, 1'b0);
                end
                2:
                begin
                    n = active_len() + $urandom_range(0, 20);
                    send_buffer(n, 1, 1'b1);
                end
                default:
                begin
                    n = active_len() + $urandom_range(0, 24);
                    if (n == 0)
                        n = 1;
                    send_buffer(n, $urandom_range(1, 3), 1'b0);
                end
            endcase
            phase_bytes += n;
        end
        drain();
    endtask

    // every byte matches, so results pile up behind the stalled receiver
    task automatic backpressure_phase();
        set_config('0, '0, '0, 5'd1, rand64(), '0);
        hold_req = 1'b1;
        repeat (60) send_byte(8'($urandom), $urandom_range(9) == 0);
        send_byte(8'($urandom), 1'b1);
        drain();
    endtask

    initial
    begin
        int phase;
        tracker = new();
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: length one, all wildcards, every byte matches
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h5A, 1'b1);
        send_byte(8'h11, 1'b1);
        drain();

        // FF 00 FF, address sum wraps past the top; second buffer too short
        set_config(64'h0000_0000_00FF_00FF, '0, 16'h0007, 5'd3, '1, '0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b1);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h00, 1'b1);
        drain();

        // oversized length, only the top pattern byte cared for, limit of one
        set_config('0, 64'hA500_0000_0000_0000, 16'h8000, 5'd31,
                   64'h0000_0000_0000_1000, 32'd1);
        repeat (15) send_byte(8'h00, 1'b0);
        send_byte(8'hA5, 1'b0);
        send_byte(8'hA5, 1'b1);
        drain();

        // zero length never matches, even with all wildcards
        set_config('1, '1, '0, 5'd0, '1, '1);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h00, 1'b1);
        drain();

        phase = 0;
        while (bytes_sent < TARGET_BYTES)
        begin
            idling_on = !(phase >= 4 && phase < 8);
            if (phase == 2)
                backpressure_phase();
            else
                random_phase(40);
            phase++;
        end
        idling_on = 1'b1;
        drain();

        if (tracker.errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

FILE: sim.f
rtl/core/mbps_pkg.sv
rtl/core/mbps_match.sv
rtl/core/masked_byte_pattern_scan.sv
sim/masked_byte_pattern_scan_test.sv
